// ----- rtl/twe_pkg.sv -----
package twe_pkg;

  // Build-time sizing of the event builder.
  localparam int NUM_CHANNELS = 36;
  localparam int TIME_BITS    = 48;
  localparam int ENERGY_BITS  = 16;

  // Fixed port widths.
  localparam int CH_PORT_W   = 6;
  localparam int MASK_PORT_W = 36;
  localparam int WINDOW_W    = 32;

  // Memory index width and the width of one stored entry.
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int KEPT_W = TIME_BITS + ENERGY_BITS;

  // Signed width that holds a timestamp difference and the window.
  localparam int DIFF_W = (TIME_BITS + 2 > WINDOW_W + 2) ? TIME_BITS + 2 : WINDOW_W + 2;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_WINDOW = 1'b0;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd1000;

  // Input operation codes.
  localparam logic OP_HIT   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DR_ISSUE,
    ST_DR_LOAD
  } twe_state_t;

  // Request from the sequencer to the kept-hit memory.
  typedef struct packed {
    logic              rd_en;
    logic [CH_W-1:0]   rd_addr;
    logic              wr_en;
    logic [CH_W-1:0]   wr_addr;
    logic [KEPT_W-1:0] wr_data;
  } mem_req_t;

endpackage

// ----- rtl/twe_hit_if.sv -----
interface twe_hit_if import twe_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [CH_PORT_W-1:0]   hit_channel;
  logic [TIME_BITS-1:0]   hit_time;
  logic [ENERGY_BITS-1:0] hit_energy;

  modport source (output valid, operation, hit_channel, hit_time, hit_energy, input ready);
  modport sink (input valid, operation, hit_channel, hit_time, hit_energy, output ready);
endinterface

// ----- rtl/twe_rec_if.sv -----
interface twe_rec_if import twe_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CH_PORT_W-1:0]   out_channel;
  logic [TIME_BITS-1:0]   out_time;
  logic [ENERGY_BITS-1:0] out_energy;
  logic [MASK_PORT_W-1:0] event_channels;
  logic [TIME_BITS-1:0]   event_start;
  logic                   last;

  modport source (output valid, out_channel, out_time, out_energy, event_channels,
                  event_start, last, input ready);
  modport sink (input valid, out_channel, out_time, out_energy, event_channels,
                event_start, last, output ready);
endinterface

// ----- rtl/twe_kept_mem.sv -----
module twe_kept_mem import twe_pkg::*; (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [KEPT_W-1:0] rd_data
);

  // One entry per channel: kept timestamp above kept energy.
  logic [KEPT_W-1:0] mem [NUM_CHANNELS];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ----- rtl/twe_apb_regs.sv -----
module twe_apb_regs import twe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [WINDOW_W-1:0]   window_ticks
);

  logic reg_index;

  assign reg_index = paddr[2];
  assign pready    = 1'b1;

  // Register write in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
    end else if (psel && penable && pwrite && (reg_index == REG_WINDOW)) begin
      window_ticks <= pwdata[WINDOW_W-1:0];
    end
  end

  // Read data; addresses beyond the register list read as zero.
  always_comb begin
    prdata = '0;
    if ((paddr[1:0] == 2'b00) && (reg_index == REG_WINDOW)) begin
      prdata = APB_DATA_W'(window_ticks);
    end
  end

endmodule

// ----- rtl/twe_ctrl.sv -----
module twe_ctrl import twe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [WINDOW_W-1:0] window_ticks,
  twe_hit_if.sink             hits,
  twe_rec_if.source           records,
  output mem_req_t            mem_req,
  input  logic [KEPT_W-1:0]   mem_rd_data
);

  twe_state_t state, state_next;

  // Captured input transaction.
  logic                   op_q;
  logic [CH_PORT_W-1:0]   ch_q;
  logic [TIME_BITS-1:0]   t_q;
  logic [ENERGY_BITS-1:0] e_q;

  // Event state and drain bookkeeping.
  logic [NUM_CHANNELS-1:0] mask, mask_next;
  logic [TIME_BITS-1:0]    evt_ref, evt_ref_next;
  logic [NUM_CHANNELS-1:0] rem, rem_next;
  logic                    pend, pend_next;
  logic [CH_W-1:0]         cur_ch, cur_ch_next;

  // Output register.
  logic                   out_valid;
  logic                   out_load;
  logic [CH_PORT_W-1:0]   out_channel;
  logic [TIME_BITS-1:0]   out_time;
  logic [ENERGY_BITS-1:0] out_energy;
  logic [MASK_PORT_W-1:0] out_mask;
  logic [TIME_BITS-1:0]   out_start;
  logic                   out_last;

  logic                   accept;
  logic                   in_ch_ok;
  logic                   ch_ok;
  logic [CH_W-1:0]        chi;
  logic                   present;
  logic                   in_window;
  logic [ENERGY_BITS-1:0] kept_e;
  logic [TIME_BITS-1:0]   kept_t;
  logic [CH_W-1:0]        low_idx;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] win_ext;

  assign hits.ready = (state == ST_IDLE);
  assign accept     = hits.valid && hits.ready;
  assign in_ch_ok   = {1'b0, hits.hit_channel} < (CH_PORT_W + 1)'(NUM_CHANNELS);
  assign ch_ok      = {1'b0, ch_q} < (CH_PORT_W + 1)'(NUM_CHANNELS);
  assign chi        = ch_q[CH_W-1:0];
  assign present    = ch_ok && mask[chi];
  assign kept_t     = mem_rd_data[KEPT_W-1:ENERGY_BITS];
  assign kept_e     = mem_rd_data[ENERGY_BITS-1:0];

  // Signed distance of the hit from the reference time against the window.
  assign diff      = $signed(DIFF_W'(t_q)) - $signed(DIFF_W'(evt_ref));
  assign win_ext   = $signed(DIFF_W'(window_ticks));
  assign in_window = diff < win_ext;

  // Lowest channel still waiting to be drained.
  always_comb begin
    low_idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (rem[i]) begin
        low_idx = CH_W'(i);
      end
    end
  end

  // Capture the input transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= hits.operation;
      ch_q <= hits.hit_channel;
      t_q  <= hits.hit_time;
      e_q  <= hits.hit_energy;
    end
  end

  // State and event registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      mask    <= '0;
      evt_ref <= '0;
      rem     <= '0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      mask    <= mask_next;
      evt_ref <= evt_ref_next;
      rem     <= rem_next;
      pend    <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_ch <= cur_ch_next;
  end

  // Sequencer: decide on a hit after its entry is read, or walk the event.
  always_comb begin
    state_next      = state;
    mask_next       = mask;
    evt_ref_next    = evt_ref;
    rem_next        = rem;
    pend_next       = pend;
    cur_ch_next     = cur_ch;
    out_load        = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = hits.hit_channel[CH_W-1:0];
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = chi;
    mem_req.wr_data = {t_q, e_q};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          mem_req.rd_en = in_ch_ok;
          state_next    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (op_q == OP_FLUSH) begin
          if (mask != '0) begin
            rem_next   = mask;
            pend_next  = 1'b0;
            state_next = ST_DR_ISSUE;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (mask == '0) begin
          // First hit opens the event and sets the reference time.
          evt_ref_next  = t_q;
          mem_req.wr_en = ch_ok;
          if (ch_ok) begin
            mask_next = mask | (NUM_CHANNELS'(1) << chi);
          end
          state_next = ST_IDLE;
        end else if (in_window) begin
          // Keep the hit if the channel is new or the energy is higher.
          if (ch_ok && (!present || (e_q > kept_e))) begin
            mem_req.wr_en = 1'b1;
            mask_next     = mask | (NUM_CHANNELS'(1) << chi);
          end
          state_next = ST_IDLE;
        end else begin
          // Outside the window: drain first, then open with this hit.
          rem_next   = mask;
          pend_next  = 1'b1;
          state_next = ST_DR_ISSUE;
        end
      end
      ST_DR_ISSUE: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = low_idx;
        cur_ch_next     = low_idx;
        rem_next        = rem & ~(NUM_CHANNELS'(1) << low_idx);
        state_next      = ST_DR_LOAD;
      end
      ST_DR_LOAD: begin
        if (!out_valid || records.ready) begin
          out_load = 1'b1;
          if (rem != '0) begin
            state_next = ST_DR_ISSUE;
          end else begin
            mask_next = '0;
            if (pend) begin
              evt_ref_next  = t_q;
              mem_req.wr_en = ch_ok;
              if (ch_ok) begin
                mask_next = NUM_CHANNELS'(1) << chi;
              end
            end
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register, refilled while the previous record is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (records.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel <= CH_PORT_W'(cur_ch);
      out_time    <= kept_t;
      out_energy  <= kept_e;
      out_mask    <= MASK_PORT_W'(mask);
      out_start   <= evt_ref;
      out_last    <= (rem == '0);
    end
  end

  assign records.valid          = out_valid;
  assign records.out_channel    = out_channel;
  assign records.out_time       = out_time;
  assign records.out_energy     = out_energy;
  assign records.event_channels = out_mask;
  assign records.event_start    = out_start;
  assign records.last           = out_last;

endmodule

// ----- rtl/time_window_event_builder.sv -----
// Time-window event builder. Hits (channel, timestamp, energy) are grouped into events: the
// first hit sets the reference time, later hits join while their signed time minus the
// reference is below window_ticks, and each channel keeps its highest-energy hit (the earlier
// one on a tie). A hit outside the window, or a flush transaction, drains the open event as
// one record per present channel in ascending channel order, with last on the final record;
// hits on channels at or above the channel count are never kept. An input transaction reads
// the channel's kept entry from the synchronous memory, then is decided and written back. A
// drain adds a memory read and an output load per present channel, plus any record sink
// stalls; no new transaction is taken until the last is done. The kept-hit memory needs no
// clearing after reset, since entry data is only used while its channel is marked present.
module time_window_event_builder import twe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  twe_hit_if.sink               hits,
  twe_rec_if.source             records
);

  logic [WINDOW_W-1:0] window_ticks;
  mem_req_t            mem_req;
  logic [KEPT_W-1:0]   mem_rd_data;

  // Configuration registers.
  twe_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .window_ticks (window_ticks)
  );

  // Event sequencer.
  twe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .window_ticks (window_ticks),
    .hits         (hits),
    .records      (records),
    .mem_req      (mem_req),
    .mem_rd_data  (mem_rd_data)
  );

  // Kept hit per channel.
  twe_kept_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule

// ----- sim/tb.sv -----
module tb;
  import twe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};
  localparam int unsigned PHASE_SETTLE = 8;
  localparam int unsigned END_SETTLE = 100;

  // One input transaction as offered to the block, plus a flag that holds it back until
  // every record already due has come out.
  typedef struct {
    logic                   op;
    logic [CH_PORT_W-1:0]   channel;
    logic [TIME_BITS-1:0]   stamp;
    logic [ENERGY_BITS-1:0] energy;
    bit                     wait_idle;
  } hit_item_t;

  typedef struct {
    logic [CH_PORT_W-1:0]   channel;
    logic [TIME_BITS-1:0]   stamp;
    logic [ENERGY_BITS-1:0] energy;
    logic [MASK_PORT_W-1:0] mask;
    logic [TIME_BITS-1:0]   start;
    logic                   last;
  } event_record_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  twe_hit_if hit_bus();
  twe_rec_if rec_bus();

  time_window_event_builder dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hits    (hit_bus),
    .records (rec_bus)
  );

  // Stimulus waiting to be sent, transactions taken by the block, and records still due.
  hit_item_t     hit_queue[$];
  hit_item_t     taken_hits[$];
  event_record_t expected_records[$];

  // Predicted state of the event builder.
  logic [WINDOW_W-1:0]    window_ticks = WINDOW_RESET;
  logic [MASK_PORT_W-1:0] open_mask = '0;
  logic [TIME_BITS-1:0]   event_ref = '0;
  logic [TIME_BITS-1:0]   kept_stamp[NUM_CHANNELS];
  logic [ENERGY_BITS-1:0] kept_energy[NUM_CHANNELS];

  bit          no_results_due = 1'b1;
  bit          no_idle = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mostly short gaps, now and then a long one; none at all while no_idle is set.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Keep the hit with the highest energy per channel; on a tie the earlier one stays.
  function automatic void keep_hit(hit_item_t it);
    if (int'(it.channel) >= NUM_CHANNELS) return;
    if (!open_mask[it.channel] || it.energy > kept_energy[it.channel]) begin
      open_mask[it.channel] = 1'b1;
      kept_stamp[it.channel] = it.stamp;
      kept_energy[it.channel] = it.energy;
    end
  endfunction

  // Emit one record per present channel in ascending order and close the event.
  function automatic void drain_event();
    event_record_t r;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      if (open_mask[ch]) begin
        r.channel = CH_PORT_W'(ch);
        r.stamp = kept_stamp[ch];
        r.energy = kept_energy[ch];
        r.mask = open_mask;
        r.start = event_ref;
        r.last = (open_mask >> (ch + 1)) == '0;
        expected_records.push_back(r);
      end
    end
    open_mask = '0;
  endfunction

  function automatic void build_events(hit_item_t it);
    longint diff;
    if (it.op == OP_FLUSH) begin
      if (open_mask != '0) drain_event();
    end else if (open_mask == '0) begin
      keep_hit(it);
      event_ref = it.stamp;
    end else begin
      diff = $signed({16'd0, it.stamp}) - $signed({16'd0, event_ref});
      if (diff < $signed({32'd0, window_ticks})) begin
        keep_hit(it);
      end else begin
        drain_event();
        keep_hit(it);
        event_ref = it.stamp;
      end
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Hit driver: offer the head of the queue, hold it until accepted, then idle a while.
  always @(posedge clk) begin
    if (rst) begin
      hit_bus.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (hit_bus.valid && hit_bus.ready) begin
        taken_hits.push_back(hit_queue.pop_front());
        gap_left = idle_gap();
      end
      if (hit_bus.valid && !hit_bus.ready) begin
        // Payload stays put until the transaction completes.
      end else if (gap_left != 0) begin
        gap_left--;
        hit_bus.valid <= 1'b0;
      end else if (hit_queue.size() != 0 && !(hit_queue[0].wait_idle &&
                   (taken_hits.size() != 0 || !no_results_due))) begin
        hit_bus.operation <= hit_queue[0].op;
        hit_bus.hit_channel <= hit_queue[0].channel;
        hit_bus.hit_time <= hit_queue[0].stamp;
        hit_bus.hit_energy <= hit_queue[0].energy;
        hit_bus.valid <= 1'b1;
      end else begin
        hit_bus.valid <= 1'b0;
      end
    end
  end

  // Prediction runs on the falling edge after acceptance, so the record monitor never races it.
  always @(negedge clk) begin
    while (taken_hits.size() != 0) build_events(taken_hits.pop_front());
    no_results_due = expected_records.size() == 0;
  end

  // Record monitor: compare each transaction with the oldest expected record.
  always @(posedge clk) begin
    if (rst) begin
      rec_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rec_bus.valid && rec_bus.ready) begin
        if (expected_records.size() == 0) begin
          $error("unexpected record: out_channel %0d, out_time 0x%0h",
                 rec_bus.out_channel, rec_bus.out_time);
          mismatches++;
        end else begin
          event_record_t want;
          want = expected_records.pop_front();
          check_field("out_channel", 64'(want.channel), 64'(rec_bus.out_channel));
          check_field("out_time", 64'(want.stamp), 64'(rec_bus.out_time));
          check_field("out_energy", 64'(want.energy), 64'(rec_bus.out_energy));
          check_field("event_channels", 64'(want.mask), 64'(rec_bus.event_channels));
          check_field("event_start", 64'(want.start), 64'(rec_bus.event_start));
          check_field("last", 64'(want.last), 64'(rec_bus.last));
        end
        stall_left = idle_gap();
      end
      if (stall_left != 0) begin
        stall_left--;
        rec_bus.ready <= 1'b0;
      end else begin
        rec_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_hit(int unsigned ch, logic [TIME_BITS-1:0] stamp,
                          logic [ENERGY_BITS-1:0] energy, bit wait_idle = 1'b0);
    hit_item_t it;
    it.op = OP_HIT;
    it.channel = CH_PORT_W'(ch);
    it.stamp = stamp;
    it.energy = energy;
    it.wait_idle = wait_idle;
    hit_queue.push_back(it);
  endtask

  // Hit fields of a flush are don't-care, so they carry random values.
  task automatic push_flush();
    hit_item_t it;
    it.op = OP_FLUSH;
    it.channel = CH_PORT_W'($urandom);
    it.stamp = TIME_BITS'({$urandom, $urandom});
    it.energy = ENERGY_BITS'($urandom);
    it.wait_idle = 1'b0;
    hit_queue.push_back(it);
  endtask

  // Mostly well-formed events (first hit outside the previous window, later hits inside
  // it or slightly earlier), with some stray hits and flushes mixed in.
  task automatic queue_random_events(int unsigned target);
    hit_item_t            it;
    int unsigned          made;
    int unsigned          roll;
    int unsigned          n_hits;
    int unsigned          rot;
    bit                   full;
    logic [TIME_BITS-1:0] start;
    made = 0;
    start = TIME_BITS'({$urandom, $urandom});
    while (made < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        push_flush();
        made++;
      end else if (roll < 10) begin
        it.op = OP_HIT;
        it.channel = CH_PORT_W'($urandom);
        it.stamp = TIME_BITS'({$urandom, $urandom});
        it.energy = ENERGY_BITS'($urandom);
        it.wait_idle = 1'b0;
        hit_queue.push_back(it);
        if (int'(it.channel) < NUM_CHANNELS) made++;
      end else begin
        if ($urandom_range(0, 9) == 0) start = TIME_BITS'({$urandom, $urandom});
        full = $urandom_range(0, 14) == 0;
        n_hits = full ? NUM_CHANNELS : $urandom_range(1, 8);
        rot = $urandom_range(0, NUM_CHANNELS - 1);
        for (int i = 0; i < n_hits; i++) begin
          it.op = OP_HIT;
          // A full event visits every channel once, in a scrambled order.
          if (full) begin
            it.channel = CH_PORT_W'((i * 7 + rot) % NUM_CHANNELS);
          end else if ($urandom_range(0, 9) == 0) begin
            it.channel = CH_PORT_W'($urandom_range(NUM_CHANNELS, 63));
          end else begin
            it.channel = CH_PORT_W'($urandom_range(0, NUM_CHANNELS - 1));
          end
          if (i == 0) begin
            it.stamp = start;
          end else begin
            roll = $urandom_range(0, 9);
            if (window_ticks == '0 || roll == 0) begin
              it.stamp = start - TIME_BITS'($urandom_range(0, 50));
            end else if (roll == 1) begin
              it.stamp = start + TIME_BITS'(window_ticks) - TIME_BITS'(1);
            end else begin
              it.stamp = start + TIME_BITS'($urandom_range(0, window_ticks - 1));
            end
          end
          // Small energies make ties on a channel common.
          if ($urandom_range(0, 3) == 0) begin
            it.energy = ENERGY_BITS'($urandom_range(0, 3));
          end else begin
            it.energy = ENERGY_BITS'($urandom);
          end
          it.wait_idle = (i == 0) && ($urandom_range(0, 39) == 0);
          hit_queue.push_back(it);
          if (int'(it.channel) < NUM_CHANNELS) made++;
        end
        if ($urandom_range(0, 6) == 0) begin
          push_flush();
          made++;
        end
        start = start + TIME_BITS'(window_ticks) + TIME_BITS'($urandom_range(0, 3));
      end
    end
  endtask

  // Wait until every queued transaction is taken and every record has arrived.
  task automatic wait_quiet(int unsigned settle);
    do @(negedge clk);
    while (hit_queue.size() != 0 || hit_bus.valid || taken_hits.size() != 0 ||
           expected_records.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_window(logic [WINDOW_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WINDOW_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    window_ticks = value;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hit_bus.valid = 1'b0;
    hit_bus.operation = OP_HIT;
    hit_bus.hit_channel = '0;
    hit_bus.hit_time = '0;
    hit_bus.hit_energy = '0;
    rec_bus.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset window: flush of an empty builder, ties, a hit before the reference time,
    // ignored channels inside and outside the window, and extreme field values.
    push_flush();
    push_hit(0, 100, 0);
    push_hit(35, 150, '1);
    push_hit(0, 200, 0);
    push_hit(0, 90, 5);
    push_hit(40, 300, 9);
    push_hit(63, 1100, 1);
    push_hit(63, '1, '1);
    push_hit(10, 5500, 100, 1'b1);
    push_hit(11, 6499, 0);
    push_flush();
    push_hit(35, '1, '1);
    push_hit(34, 0, 1);
    push_flush();
    push_hit(NUM_CHANNELS, 0, 0);
    push_flush();
    wait_quiet(PHASE_SETTLE);

    // Zero window: only hits earlier than the reference join.
    write_window('0);
    push_hit(1, 1000, 7);
    push_hit(2, 1000, 8);
    push_hit(3, 999, 9);
    push_flush();
    queue_random_events(25);
    wait_quiet(PHASE_SETTLE);

    // Widest window.
    write_window('1);
    push_hit(4, 0, 1);
    push_hit(5, 48'hFFFF_FFFE, 2);
    push_hit(6, 48'hFFFF_FFFF, 3);
    push_flush();
    queue_random_events(25);
    wait_quiet(PHASE_SETTLE);

    // Back-to-back traffic on both sides.
    write_window(WINDOW_W'($urandom_range(1, 5000)));
    no_idle = 1'b1;
    queue_random_events(40);
    wait_quiet(PHASE_SETTLE);
    no_idle = 1'b0;

    write_window(WINDOW_RESET);
    queue_random_events(70);
    wait_quiet(PHASE_SETTLE);

    write_window(WINDOW_W'($urandom_range(1, 64)));
    queue_random_events(40);
    wait_quiet(END_SETTLE);

    if (mismatches == 0) begin
      $display("time_window_event_builder regression: pass");
    end else begin
      $display("time_window_event_builder regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("time_window_event_builder regression: fail");
    $finish;
  end

endmodule
